// File: hdl/svm_pkg.sv
package svm_pkg;

  localparam int NEXT_PC_W = 12;

  localparam logic [5:0] OP_IMM  = 6'd0;
  localparam logic [5:0] OP_LEA  = 6'd1;
  localparam logic [5:0] OP_JMP  = 6'd2;
  localparam logic [5:0] OP_JZ   = 6'd3;
  localparam logic [5:0] OP_JNZ  = 6'd4;
  localparam logic [5:0] OP_NVAR = 6'd5;
  localparam logic [5:0] OP_DARG = 6'd6;
  localparam logic [5:0] OP_CALL = 6'd7;
  localparam logic [5:0] OP_LI   = 6'd8;
  localparam logic [5:0] OP_LC   = 6'd9;
  localparam logic [5:0] OP_SI   = 6'd10;
  localparam logic [5:0] OP_SC   = 6'd11;
  localparam logic [5:0] OP_PUSH = 6'd12;
  localparam logic [5:0] OP_OR   = 6'd13;
  localparam logic [5:0] OP_XOR  = 6'd14;
  localparam logic [5:0] OP_AND  = 6'd15;
  localparam logic [5:0] OP_EQ   = 6'd16;
  localparam logic [5:0] OP_NE   = 6'd17;
  localparam logic [5:0] OP_LT   = 6'd18;
  localparam logic [5:0] OP_GT   = 6'd19;
  localparam logic [5:0] OP_LE   = 6'd20;
  localparam logic [5:0] OP_GE   = 6'd21;
  localparam logic [5:0] OP_SHL  = 6'd22;
  localparam logic [5:0] OP_SHR  = 6'd23;
  localparam logic [5:0] OP_ADD  = 6'd24;
  localparam logic [5:0] OP_SUB  = 6'd25;
  localparam logic [5:0] OP_MUL  = 6'd26;
  localparam logic [5:0] OP_DIV  = 6'd27;
  localparam logic [5:0] OP_MOD  = 6'd28;
  localparam logic [5:0] OP_RET  = 6'd29;
  localparam logic [5:0] OP_EXIT = 6'd38;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EXITED  = 3'd1;
  localparam logic [2:0] ST_DIVZERO = 3'd2;
  localparam logic [2:0] ST_UNSUP   = 3'd3;
  localparam logic [2:0] ST_FAULT   = 3'd4;
  localparam logic [2:0] ST_HALTED  = 3'd5;

  typedef struct packed {
    logic [5:0]         opcode;
    logic signed [63:0] operand;
  } in_t;

  typedef struct packed {
    logic [NEXT_PC_W-1:0] next_pc;
    logic signed [63:0]   acc_value;
    logic [2:0]           status;
    logic signed [63:0]   exit_value;
  } out_t;

endpackage

// File: hdl/stack_vm_execute_core.sv
// Executes one instruction per word. Each word passes through decode, up to two memory
// reads (byte stores and returns take the second) and, for multiply, divide and modulo, an
// iterative step. Multiply uses one shared 32x32 multiplier, three partial products;
// divide and modulo use a restoring divider, one quotient bit per cycle. The next word is
// taken once the result has moved to the output register. After reset a clearing pass
// zeroes all MEM_WORDS data memory words, one word per cycle, before the first is taken.
module stack_vm_execute_core #(
  parameter int MEM_WORDS  = 4096,
  parameter int CODE_WORDS = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  svm_pkg::in_t             in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output svm_pkg::out_t            out_data,
  input  logic                     cfg_write_en,
  input  logic [11:0]              cfg_write_data
);

  localparam int AW        = $clog2(MEM_WORDS);
  localparam int PW        = AW + 4;
  localparam int SW        = PW + 2;
  localparam int CW        = $clog2(CODE_WORDS);
  localparam int PCW       = (CW > 12) ? CW : 12;
  localparam int MEM_BYTES = MEM_WORDS * 8;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DEC   = 9'b000000100,
    S_RD1   = 9'b000001000,
    S_RD2   = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_DFIN  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_cnt;
  logic [5:0]      op;
  logic [63:0]     imm;
  logic [63:0]     acc;
  logic [PW-1:0]   sp;
  logic [PW-1:0]   fp;
  logic [PCW-1:0]  pc;
  logic            halted;
  logic [2:0]      st;
  logic [63:0]     ex;
  logic [PW-1:0]   sc_addr;
  logic [PW-1:0]   lb;
  logic            lb_ok;
  logic [63:0]     a_reg;
  logic [1:0]      mcnt;
  logic [63:0]     mul_out;
  logic [63:0]     prod;
  logic [63:0]     quo;
  logic [63:0]     rem;
  logic [63:0]     dvs;
  logic [5:0]      dcnt;
  logic            neg_q;
  logic            neg_r;

  logic [63:0]     mem [MEM_WORDS];
  logic [63:0]     rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [63:0]     mem_wdata;
  logic [AW-1:0]   mem_raddr;

  logic [63:0]     imm_mag;
  logic            small_imm;
  logic            taken_ok;
  logic signed [SW-1:0] sv;
  logic signed [SW-1:0] sp_s;
  logic signed [SW-1:0] nvar_moved;
  logic signed [SW-1:0] darg_moved;
  logic            nvar_ok;
  logic            darg_ok;
  logic            acc_word_ok;
  logic            acc_byte_ok;
  logic            sp_word_ok;
  logic            sp_ge8;
  logic            ret_ok;
  logic            jump_cond;
  logic [PCW-1:0]  adv1;
  logic [PCW-1:0]  adv2;
  logic [PCW:0]    sum1;
  logic [PCW:0]    sum2;
  logic            rd_word_ok;
  logic            rd_byte_ok;
  logic [7:0]      rd_byte;
  logic [63:0]     lc_value;
  logic [63:0]     alu;
  logic [63:0]     sc_merged;
  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic [64:0]     div_trial;
  logic [64:0]     div_diff;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_comb begin
    sum1 = {1'b0, pc} + (PCW+1)'(1);
    sum2 = {1'b0, pc} + (PCW+1)'(2);
    if (sum1 >= (PCW+1)'(CODE_WORDS)) sum1 = sum1 - (PCW+1)'(CODE_WORDS);
    if (sum2 >= (PCW+1)'(CODE_WORDS)) sum2 = sum2 - (PCW+1)'(CODE_WORDS);
    adv1 = sum1[PCW-1:0];
    adv2 = sum2[PCW-1:0];

    imm_mag    = imm[63] ? (64'd0 - imm) : imm;
    small_imm  = imm_mag <= 64'(MEM_WORDS);
    taken_ok   = imm < 64'(CODE_WORDS);
    sv         = small_imm ? imm[SW-1:0] : '0;
    sp_s       = $signed({2'b00, sp});
    nvar_moved = sp_s - SW'(8) - (sv <<< 3);
    darg_moved = sp_s + (sv <<< 3);
    sp_ge8     = sp >= PW'(8);
    nvar_ok    = sp_ge8 && small_imm && !nvar_moved[SW-1] && nvar_moved <= SW'(MEM_BYTES);
    darg_ok    = small_imm && !darg_moved[SW-1] && darg_moved <= SW'(MEM_BYTES);
    acc_word_ok = (acc[2:0] == 3'd0) && (acc < 64'(MEM_BYTES));
    acc_byte_ok = acc < 64'(MEM_BYTES);
    sp_word_ok  = (sp[2:0] == 3'd0) && (sp < PW'(MEM_BYTES));
    ret_ok      = ({1'b0, fp} + (PW+1)'(16)) <= (PW+1)'(MEM_BYTES);
    jump_cond   = (op == svm_pkg::OP_JZ) == (acc == 64'd0);

    rd_word_ok = (rdata[2:0] == 3'd0) && (rdata < 64'(MEM_BYTES));
    rd_byte_ok = rdata < 64'(MEM_BYTES);
    rd_byte    = 8'(rdata >> {acc[2:0], 3'b000});
    lc_value   = {{56{rd_byte[7]}}, rd_byte};

    alu = '0;
    case (op)
      svm_pkg::OP_OR:  alu = rdata | acc;
      svm_pkg::OP_XOR: alu = rdata ^ acc;
      svm_pkg::OP_AND: alu = rdata & acc;
      svm_pkg::OP_EQ:  alu = 64'(rdata == acc);
      svm_pkg::OP_NE:  alu = 64'(rdata != acc);
      svm_pkg::OP_LT:  alu = 64'($signed(rdata) < $signed(acc));
      svm_pkg::OP_GT:  alu = 64'($signed(rdata) > $signed(acc));
      svm_pkg::OP_LE:  alu = 64'($signed(rdata) <= $signed(acc));
      svm_pkg::OP_GE:  alu = 64'($signed(rdata) >= $signed(acc));
      svm_pkg::OP_SHL: alu = (|acc[63:6]) ? 64'd0 : (rdata << acc[5:0]);
      svm_pkg::OP_SHR: alu = (|acc[63:6]) ? {64{rdata[63]}}
                                         : 64'($signed(rdata) >>> acc[5:0]);
      svm_pkg::OP_ADD: alu = rdata + acc;
      svm_pkg::OP_SUB: alu = rdata - acc;
      default:         alu = '0;
    endcase

    sc_merged = rdata;
    for (int i = 0; i < 8; i++) begin
      if (sc_addr[2:0] == 3'(i)) sc_merged[i*8 +: 8] = acc[7:0];
    end

    case (mcnt)
      2'd0:    begin mul_a = a_reg[31:0];  mul_b = acc[31:0];  end
      2'd1:    begin mul_a = a_reg[31:0];  mul_b = acc[63:32]; end
      default: begin mul_a = a_reg[63:32]; mul_b = acc[31:0];  end
    endcase

    div_trial = {rem, quo[63]};
    div_diff  = div_trial - {1'b0, dvs};

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = sp[AW+2:3];
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      S_DEC: begin
        if (op == svm_pkg::OP_LI || op == svm_pkg::OP_LC) begin
          mem_raddr = acc[AW+2:3];
        end else if (op == svm_pkg::OP_RET) begin
          mem_raddr = fp[AW+2:3];
        end
        mem_waddr = sp[AW+2:3] - AW'(1);
        if (!halted) begin
          if (op == svm_pkg::OP_NVAR && nvar_ok) begin
            mem_we    = 1'b1;
            mem_wdata = 64'(fp);
          end else if (op == svm_pkg::OP_CALL && sp_ge8 && taken_ok) begin
            mem_we    = 1'b1;
            mem_wdata = 64'(adv2);
          end else if (op == svm_pkg::OP_PUSH && sp_ge8) begin
            mem_we    = 1'b1;
            mem_wdata = acc;
          end
        end
      end
      S_RD1: begin
        if (op == svm_pkg::OP_RET) begin
          mem_raddr = fp[AW+2:3] + AW'(1);
        end else begin
          mem_raddr = rdata[AW+2:3];
        end
        mem_waddr = rdata[AW+2:3];
        mem_wdata = acc;
        mem_we    = (op == svm_pkg::OP_SI) && rd_word_ok;
      end
      S_RD2: begin
        mem_waddr = sc_addr[AW+2:3];
        mem_wdata = sc_merged;
        mem_we    = (op == svm_pkg::OP_SC);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      acc       <= '0;
      sp        <= PW'(MEM_BYTES);
      fp        <= PW'(MEM_BYTES);
      pc        <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_write_en) pc <= PCW'(cfg_write_data);
      mul_out <= mul_a * mul_b;

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MEM_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op    <= in_data.opcode;
            imm   <= in_data.operand;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          st    <= svm_pkg::ST_OK;
          ex    <= '0;
          state <= S_DONE;
          if (halted) begin
            st <= svm_pkg::ST_HALTED;
          end else begin
            case (op)
              svm_pkg::OP_IMM: begin
                acc <= imm;
                pc  <= adv2;
              end
              svm_pkg::OP_LEA: begin
                acc <= 64'(fp) + (imm << 3);
                pc  <= adv2;
              end
              svm_pkg::OP_JMP, svm_pkg::OP_JZ, svm_pkg::OP_JNZ: begin
                if (op != svm_pkg::OP_JMP && !jump_cond) begin
                  pc <= adv2;
                end else if (taken_ok) begin
                  pc <= imm[PCW-1:0];
                end else begin
                  st <= svm_pkg::ST_FAULT;
                end
              end
              svm_pkg::OP_NVAR: begin
                if (nvar_ok) begin
                  fp <= sp - PW'(8);
                  sp <= nvar_moved[PW-1:0];
                  pc <= adv2;
                end else begin
                  st <= svm_pkg::ST_FAULT;
                end
              end
              svm_pkg::OP_DARG: begin
                if (darg_ok) begin
                  sp <= darg_moved[PW-1:0];
                  pc <= adv2;
                end else begin
                  st <= svm_pkg::ST_FAULT;
                end
              end
              svm_pkg::OP_CALL: begin
                if (sp_ge8 && taken_ok) begin
                  sp <= sp - PW'(8);
                  pc <= imm[PCW-1:0];
                end else begin
                  st <= svm_pkg::ST_FAULT;
                end
              end
              svm_pkg::OP_LI: begin
                if (acc_word_ok) state <= S_RD1;
                else st <= svm_pkg::ST_FAULT;
              end
              svm_pkg::OP_LC: begin
                if (acc_byte_ok) state <= S_RD1;
                else st <= svm_pkg::ST_FAULT;
              end
              svm_pkg::OP_SI, svm_pkg::OP_SC, svm_pkg::OP_EXIT: begin
                if (sp_word_ok) state <= S_RD1;
                else st <= svm_pkg::ST_FAULT;
              end
              svm_pkg::OP_PUSH: begin
                if (sp_ge8) begin
                  sp <= sp - PW'(8);
                  pc <= adv1;
                end else begin
                  st <= svm_pkg::ST_FAULT;
                end
              end
              svm_pkg::OP_RET: begin
                if (ret_ok) state <= S_RD1;
                else st <= svm_pkg::ST_FAULT;
              end
              default: begin
                if (op inside {[svm_pkg::OP_OR:svm_pkg::OP_MOD]}) begin
                  if (!sp_word_ok) begin
                    st <= svm_pkg::ST_FAULT;
                  end else if ((op == svm_pkg::OP_DIV || op == svm_pkg::OP_MOD)
                               && acc == 64'd0) begin
                    st <= svm_pkg::ST_DIVZERO;
                  end else begin
                    state <= S_RD1;
                  end
                end else begin
                  st <= svm_pkg::ST_UNSUP;
                end
              end
            endcase
          end
        end
        S_RD1: begin
          state <= S_DONE;
          case (op)
            svm_pkg::OP_LI: begin
              acc <= rdata;
              pc  <= adv1;
            end
            svm_pkg::OP_LC: begin
              acc <= lc_value;
              pc  <= adv1;
            end
            svm_pkg::OP_SI: begin
              if (rd_word_ok) begin
                sp <= sp + PW'(8);
                pc <= adv1;
              end else begin
                st <= svm_pkg::ST_FAULT;
              end
            end
            svm_pkg::OP_SC: begin
              if (rd_byte_ok) begin
                sc_addr <= rdata[PW-1:0];
                state   <= S_RD2;
              end else begin
                st <= svm_pkg::ST_FAULT;
              end
            end
            svm_pkg::OP_RET: begin
              lb    <= rdata[PW-1:0];
              lb_ok <= (rdata[2:0] == 3'd0) && (rdata <= 64'(MEM_BYTES));
              state <= S_RD2;
            end
            svm_pkg::OP_EXIT: begin
              ex     <= rdata;
              st     <= svm_pkg::ST_EXITED;
              halted <= 1'b1;
              pc     <= adv1;
            end
            svm_pkg::OP_MUL: begin
              a_reg <= rdata;
              mcnt  <= 2'd0;
              state <= S_MUL;
            end
            svm_pkg::OP_DIV, svm_pkg::OP_MOD: begin
              quo   <= rdata[63] ? (64'd0 - rdata) : rdata;
              dvs   <= acc[63] ? (64'd0 - acc) : acc;
              rem   <= '0;
              dcnt  <= '0;
              neg_q <= rdata[63] ^ acc[63];
              neg_r <= rdata[63];
              state <= S_DIV;
            end
            default: begin
              acc <= alu;
              sp  <= sp + PW'(8);
              pc  <= adv1;
            end
          endcase
        end
        S_RD2: begin
          state <= S_DONE;
          if (op == svm_pkg::OP_SC) begin
            sp <= sp + PW'(8);
            pc <= adv1;
          end else if (lb_ok && rdata < 64'(CODE_WORDS)) begin
            sp <= fp + PW'(16);
            fp <= lb;
            pc <= rdata[PCW-1:0];
          end else begin
            st <= svm_pkg::ST_FAULT;
          end
        end
        S_MUL: begin
          mcnt <= mcnt + 2'd1;
          case (mcnt)
            2'd0: ;
            2'd1: prod <= mul_out;
            2'd2: prod[63:32] <= prod[63:32] + mul_out[31:0];
            default: begin
              acc   <= prod + {mul_out[31:0], 32'd0};
              sp    <= sp + PW'(8);
              pc    <= adv1;
              state <= S_DONE;
            end
          endcase
        end
        S_DIV: begin
          if (div_diff[64]) begin
            rem <= div_trial[63:0];
            quo <= {quo[62:0], 1'b0};
          end else begin
            rem <= div_diff[63:0];
            quo <= {quo[62:0], 1'b1};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) state <= S_DFIN;
        end
        S_DFIN: begin
          if (op == svm_pkg::OP_DIV) acc <= neg_q ? (64'd0 - quo) : quo;
          else acc <= neg_r ? (64'd0 - rem) : rem;
          sp    <= sp + PW'(8);
          pc    <= adv1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.next_pc    <= pc[svm_pkg::NEXT_PC_W-1:0];
            out_data.acc_value  <= acc;
            out_data.status     <= st;
            out_data.exit_value <= ex;
            out_valid           <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
